// ===== sv/lmsg_pkg.sv =====
`default_nettype none
package lmsg_pkg;

  localparam int NUM_VOICES  = 4;
  localparam int SCOPE_COUNT = 4;
  localparam int VIDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SIDX_W      = $clog2(SCOPE_COUNT);
  localparam int REG_ADDR_W  = 5;
  localparam int OFF_W       = 3;
  localparam int AV_W        = REG_ADDR_W - OFF_W;

  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [OFF_W-1:0] {
    REG_LEVEL_LO = 3'd0,
    REG_LEVEL_HI = 3'd1,
    REG_RATIO_LO = 3'd2,
    REG_RATIO_HI = 3'd3,
    REG_STEP_LO  = 3'd4,
    REG_STEP_HI  = 3'd5,
    REG_VOL_L    = 3'd6,
    REG_VOL_R    = 3'd7
  } reg_off_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PHASE,
    ST_MAP_A,
    ST_MAP_B,
    ST_MAP_W,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_MIX,
    ST_TICK
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic [REG_ADDR_W-1:0] reg_addr;
    logic [7:0]            reg_data;
  } in_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic signed [15:0] scope_voice0;
    logic signed [15:0] scope_voice1;
    logic signed [15:0] scope_voice2;
    logic signed [15:0] scope_voice3;
  } out_t;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] ratio;
    logic [15:0] step;
    logic [15:0] phase;
    logic [7:0]  vol_left;
    logic [7:0]  vol_right;
  } voice_t;

  typedef struct packed {
    logic              en;
    logic [VIDX_W-1:0] vidx;
    reg_off_t          off;
    logic [7:0]        data;
  } reg_wr_t;

  typedef struct packed {
    logic        level_en;
    logic [15:0] level;
    logic        phase_en;
    logic [15:0] phase;
  } voice_upd_t;

endpackage
`default_nettype wire

// ===== sv/lmsg_mul.sv =====
`default_nettype none
module lmsg_mul (
  input  wire logic                                   clk,
  input  wire logic signed [lmsg_pkg::MUL_A_W-1:0]    a,
  input  wire logic signed [lmsg_pkg::MUL_B_W-1:0]    b,
  output logic signed [lmsg_pkg::MUL_P_W-1:0]         prod
);
  import lmsg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
`default_nettype wire

// ===== sv/lmsg_regfile.sv =====
`default_nettype none
module lmsg_regfile (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lmsg_pkg::reg_wr_t               wr,
  input  wire logic [lmsg_pkg::VIDX_W-1:0]     ridx,
  input  wire lmsg_pkg::voice_upd_t            upd,
  output lmsg_pkg::voice_t                     rd
);
  import lmsg_pkg::*;

  logic [15:0] level     [NUM_VOICES];
  logic [15:0] ratio     [NUM_VOICES];
  logic [15:0] step      [NUM_VOICES];
  logic [15:0] phase     [NUM_VOICES];
  logic [7:0]  vol_left  [NUM_VOICES];
  logic [7:0]  vol_right [NUM_VOICES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        level[v]     <= 16'd1;
        ratio[v]     <= '0;
        step[v]      <= '0;
        phase[v]     <= '0;
        vol_left[v]  <= '0;
        vol_right[v] <= '0;
      end
    end else begin
      if (wr.en) begin
        unique case (wr.off)
          REG_LEVEL_LO: level[wr.vidx][7:0]  <= wr.data;
          REG_LEVEL_HI: level[wr.vidx][15:8] <= wr.data;
          REG_RATIO_LO: ratio[wr.vidx][7:0]  <= wr.data;
          REG_RATIO_HI: ratio[wr.vidx][15:8] <= wr.data;
          REG_STEP_LO:  step[wr.vidx][7:0]   <= wr.data;
          REG_STEP_HI:  step[wr.vidx][15:8]  <= wr.data;
          REG_VOL_L:    vol_left[wr.vidx]    <= wr.data;
          REG_VOL_R:    vol_right[wr.vidx]   <= wr.data;
          default:      ;
        endcase
      end
      if (upd.level_en) begin
        level[ridx] <= upd.level;
      end
      if (upd.phase_en) begin
        phase[ridx] <= upd.phase;
      end
    end
  end

  always_comb begin
    rd.level     = level[ridx];
    rd.ratio     = ratio[ridx];
    rd.step      = step[ridx];
    rd.phase     = phase[ridx];
    rd.vol_left  = vol_left[ridx];
    rd.vol_right = vol_right[ridx];
  end

endmodule
`default_nettype wire

// ===== sv/logistic_map_sound_generator.sv =====
// Four-voice logistic-map sound generator behind a 32-byte register bank.
// Request channel (req_valid/req_ready/req) carries register writes, register
// reads and sample ticks; response channel (rsp_valid/rsp_ready/rsp) returns
// one transaction per read or tick, none per write or unused op code.
// A write is taken on accept and the block is ready again the next cycle.
// A read loads its response into the output register from the read state.
// A tick walks the voices one after another through one shared 19x18
// multiplier: each voice passes the phase, scale-left, scale-right and mix
// states, plus map-A, map-B and map-W when its phase accumulator carries
// and the level map runs (two multiplies plus write-back); the tick state
// then loads the result. The block takes one request at a time and is not
// ready while a tick is in progress. The output register holds a response
// until taken; a finished read or tick waits for it to drain, so a stalled
// receiver stalls the request side only once a second response is ready.
// Reset (synchronous, active high) sets every level to 1 and clears ratios,
// steps, phases, volumes and the output register.
`default_nettype none
module logistic_map_sound_generator (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire lmsg_pkg::in_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output lmsg_pkg::out_t       rsp
);
  import lmsg_pkg::*;

  state_t               state, state_next;
  logic [VIDX_W-1:0]    vidx;
  reg_off_t             rd_off;
  logic                 rd_hit;
  logic signed [16:0]   ol;
  logic signed [15:0]   left_acc, right_acc;
  logic signed [15:0]   scope [SCOPE_COUNT];

  voice_t               vr;
  reg_wr_t              wr;
  voice_upd_t           upd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic                 accept;
  logic                 out_free;
  logic                 req_hit;
  logic [16:0]          phase_sum;
  logic signed [16:0]   lvl_ofs;
  logic signed [16:0]   orr;
  logic signed [17:0]   lr_sum;
  logic [7:0]           rd_byte;
  logic                 last_voice;

  function automatic logic signed [16:0] div256(input logic signed [24:0] p);
    logic signed [24:0] t;
    t = p + (p[24] ? 25'sd255 : 25'sd0);
    return t[24:8];
  endfunction

  function automatic logic signed [15:0] div4(input logic signed [16:0] x);
    logic signed [16:0] t;
    t = x + (x[16] ? 17'sd3 : 17'sd0);
    return {t[16], t[16:2]};
  endfunction

  function automatic logic signed [15:0] div2(input logic signed [17:0] x);
    logic signed [17:0] t;
    t = x + (x[17] ? 18'sd1 : 18'sd0);
    return t[16:1];
  endfunction

  lmsg_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .ridx (vidx),
    .upd  (upd),
    .rd   (vr)
  );

  lmsg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign out_free   = !rsp_valid || rsp_ready;
  assign req_hit    = int'(req.reg_addr[REG_ADDR_W-1:OFF_W]) < NUM_VOICES;
  assign phase_sum  = {1'b0, vr.phase} + {1'b0, vr.step};
  assign lvl_ofs    = $signed({1'b0, vr.level}) - 17'sd32768;
  assign orr        = div256(prod[24:0]);
  assign lr_sum     = 18'(ol) + 18'(orr);
  assign last_voice = (vidx == VIDX_W'(NUM_VOICES - 1));

  always_comb begin
    unique case (rd_off)
      REG_LEVEL_LO: rd_byte = vr.level[7:0];
      REG_LEVEL_HI: rd_byte = vr.level[15:8];
      REG_RATIO_LO: rd_byte = vr.ratio[7:0];
      REG_RATIO_HI: rd_byte = vr.ratio[15:8];
      REG_STEP_LO:  rd_byte = vr.step[7:0];
      REG_STEP_HI:  rd_byte = vr.step[15:8];
      REG_VOL_L:    rd_byte = vr.vol_left;
      REG_VOL_R:    rd_byte = vr.vol_right;
      default:      rd_byte = '0;
    endcase
  end

  always_comb begin
    wr.en   = accept && (req.op == OP_WRITE) && req_hit;
    wr.vidx = VIDX_W'(req.reg_addr[REG_ADDR_W-1:OFF_W]);
    wr.off  = reg_off_t'(req.reg_addr[OFF_W-1:0]);
    wr.data = req.reg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    upd.level_en = 1'b0;
    upd.level    = prod[31:16];
    upd.phase_en = 1'b0;
    upd.phase    = phase_sum[15:0];
    mul_a        = MUL_A_W'(lvl_ofs);
    mul_b        = $signed({10'd0, vr.vol_left});
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.op)
            OP_READ: state_next = ST_READ;
            OP_TICK: state_next = ST_PHASE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_PHASE: begin
        upd.phase_en = 1'b1;
        state_next   = phase_sum[16] ? ST_MAP_A : ST_SCALE_L;
      end
      ST_MAP_A: begin
        mul_a      = $signed({3'd0, vr.level});
        mul_b      = $signed({1'b0, 17'(vr.ratio) + 17'h10000});
        state_next = ST_MAP_B;
      end
      ST_MAP_B: begin
        mul_a      = $signed({1'b0, prod[32:15]});
        mul_b      = $signed({1'b0, 17'h10000 - {1'b0, vr.level}});
        state_next = ST_MAP_W;
      end
      ST_MAP_W: begin
        upd.level_en = 1'b1;
        state_next   = ST_SCALE_L;
      end
      ST_SCALE_L: begin
        state_next = ST_SCALE_R;
      end
      ST_SCALE_R: begin
        mul_b      = $signed({10'd0, vr.vol_right});
        state_next = ST_MIX;
      end
      ST_MIX: begin
        state_next = last_voice ? ST_TICK : ST_PHASE;
      end
      ST_TICK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && (req.op == OP_READ)) begin
      vidx   <= VIDX_W'(req.reg_addr[REG_ADDR_W-1:OFF_W]);
      rd_off <= reg_off_t'(req.reg_addr[OFF_W-1:0]);
      rd_hit <= req_hit;
    end
    if (accept && (req.op == OP_TICK)) begin
      vidx      <= '0;
      left_acc  <= '0;
      right_acc <= '0;
      for (int k = 0; k < SCOPE_COUNT; k++) begin
        scope[k] <= '0;
      end
    end
    if (state == ST_SCALE_R) begin
      ol <= div256(prod[24:0]);
    end
    if (state == ST_MIX) begin
      left_acc  <= left_acc + div4(ol);
      right_acc <= right_acc + div4(orr);
      if (int'(vidx) < SCOPE_COUNT) begin
        scope[SIDX_W'(vidx)] <= div2(lr_sum);
      end
      if (!last_voice) begin
        vidx <= vidx + VIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_READ || state == ST_TICK) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp <= '0;
    end else if (state == ST_READ && out_free) begin
      rsp.read_data    <= rd_hit ? rd_byte : 8'd0;
      rsp.left_sample  <= '0;
      rsp.right_sample <= '0;
      rsp.scope_voice0 <= '0;
      rsp.scope_voice1 <= '0;
      rsp.scope_voice2 <= '0;
      rsp.scope_voice3 <= '0;
    end else if (state == ST_TICK && out_free) begin
      rsp.read_data    <= '0;
      rsp.left_sample  <= left_acc;
      rsp.right_sample <= right_acc;
      rsp.scope_voice0 <= scope[0];
      rsp.scope_voice1 <= scope[1];
      rsp.scope_voice2 <= scope[2];
      rsp.scope_voice3 <= scope[3];
    end
  end

endmodule
`default_nettype wire

// ===== sim/lmsg_rsp_checker.sv =====
module lmsg_rsp_checker
  import lmsg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_ready,
  input  wire in_t  req,
  input  wire logic rsp_valid,
  input  wire logic rsp_ready,
  input  wire out_t rsp,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  voice_t voices [NUM_VOICES];
  out_t   due_rsp [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] logistic_next(input logic [15:0] x, input logic [15:0] r);
    logic [63:0] xw;
    logic [63:0] rw;
    logic [63:0] acc;
    xw  = {48'd0, x};
    rw  = {48'd0, r};
    acc = (xw * (rw + 64'd65536)) >> 15;
    acc = (acc * (64'd65536 - xw)) >> 16;
    return acc[15:0];
  endfunction

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic apply_request(input in_t item);
    int          vi;
    reg_off_t    off;
    out_t        res;
    logic [16:0] sum;
    int          lvl;
    int          out_l;
    int          out_r;
    int          mix_l;
    int          mix_r;
    int          scope [SCOPE_COUNT];
    vi    = int'(item.reg_addr[REG_ADDR_W-1:OFF_W]);
    off   = reg_off_t'(item.reg_addr[OFF_W-1:0]);
    res   = '0;
    mix_l = 0;
    mix_r = 0;
    for (int k = 0; k < SCOPE_COUNT; k++) scope[k] = 0;
    case (item.op)
      OP_WRITE: begin
        if (vi < NUM_VOICES) begin
          case (off)
            REG_LEVEL_LO: voices[vi].level[7:0]  = item.reg_data;
            REG_LEVEL_HI: voices[vi].level[15:8] = item.reg_data;
            REG_RATIO_LO: voices[vi].ratio[7:0]  = item.reg_data;
            REG_RATIO_HI: voices[vi].ratio[15:8] = item.reg_data;
            REG_STEP_LO:  voices[vi].step[7:0]   = item.reg_data;
            REG_STEP_HI:  voices[vi].step[15:8]  = item.reg_data;
            REG_VOL_L:    voices[vi].vol_left    = item.reg_data;
            default:      voices[vi].vol_right   = item.reg_data;
          endcase
        end
      end
      OP_READ: begin
        if (vi < NUM_VOICES) begin
          case (off)
            REG_LEVEL_LO: res.read_data = voices[vi].level[7:0];
            REG_LEVEL_HI: res.read_data = voices[vi].level[15:8];
            REG_RATIO_LO: res.read_data = voices[vi].ratio[7:0];
            REG_RATIO_HI: res.read_data = voices[vi].ratio[15:8];
            REG_STEP_LO:  res.read_data = voices[vi].step[7:0];
            REG_STEP_HI:  res.read_data = voices[vi].step[15:8];
            REG_VOL_L:    res.read_data = voices[vi].vol_left;
            default:      res.read_data = voices[vi].vol_right;
          endcase
        end
        due_rsp.push_back(res);
      end
      OP_TICK: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          sum = {1'b0, voices[v].phase} + {1'b0, voices[v].step};
          if (sum[16]) voices[v].level = logistic_next(voices[v].level, voices[v].ratio);
          voices[v].phase = sum[15:0];
          lvl   = int'(voices[v].level) - 32768;
          out_l = (lvl * int'(voices[v].vol_left)) / 256;
          out_r = (lvl * int'(voices[v].vol_right)) / 256;
          if (v < SCOPE_COUNT) scope[v] = (out_l + out_r) / 2;
          mix_l += out_l / 4;
          mix_r += out_r / 4;
        end
        res.left_sample  = mix_l[15:0];
        res.right_sample = mix_r[15:0];
        res.scope_voice0 = scope[0][15:0];
        res.scope_voice1 = scope[1][15:0];
        res.scope_voice2 = scope[2][15:0];
        res.scope_voice3 = scope[3][15:0];
        due_rsp.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_t head;
    if (rst) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        voices[v]       = '0;
        voices[v].level = 16'd1;
      end
      due_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          $error("response transaction with nothing expected, read_data %0d", rsp.read_data);
          mismatches++;
        end else begin
          head = due_rsp.pop_front();
          check_field("read_data", head.read_data, rsp.read_data);
          check_field("left_sample", head.left_sample, rsp.left_sample);
          check_field("right_sample", head.right_sample, rsp.right_sample);
          check_field("scope_voice0", head.scope_voice0, rsp.scope_voice0);
          check_field("scope_voice1", head.scope_voice1, rsp.scope_voice1);
          check_field("scope_voice2", head.scope_voice2, rsp.scope_voice2);
          check_field("scope_voice3", head.scope_voice3, rsp.scope_voice3);
        end
      end
      if (req_valid && req_ready) apply_request(req);
    end
    outstanding = due_rsp.size();
  end

endmodule

// ===== sim/logistic_map_sound_generator_tb.sv =====
module logistic_map_sound_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmsg_pkg::*;

  localparam op_t OP_UNUSED     = op_t'(2'd3);
  localparam int  LONG_HOLD     = 200;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  TAIL_CYCLES   = 40;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit hold_req     = 1'b0;
  bit hold_busy    = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logistic_map_sound_generator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lmsg_rsp_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic logic [REG_ADDR_W-1:0] reg_addr_of(input int voice, input reg_off_t off);
    logic [AV_W-1:0] vsel;
    vsel = voice[AV_W-1:0];
    return {vsel, off};
  endfunction

  function automatic logic [REG_ADDR_W-1:0] rand_addr();
    return REG_ADDR_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] rand_data();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(input op_t op, input logic [REG_ADDR_W-1:0] addr, input logic [7:0] data);
    in_t item;
    item.op       = op;
    item.reg_addr = addr;
    item.reg_data = data;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic wait_for_responses();
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic run_random(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send(OP_UNUSED, rand_addr(), rand_data());
      end else begin
        sent++;
        if (pick < 40) send(OP_WRITE, rand_addr(), rand_data());
        else if (pick < 58) send(OP_READ, rand_addr(), rand_data());
        else send(OP_TICK, rand_addr(), rand_data());
      end
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_busy = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_busy = 1'b0;
        hold_req  = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send(OP_READ, reg_addr_of(0, REG_LEVEL_LO), 8'h00);
    send(OP_TICK, reg_addr_of(0, REG_LEVEL_LO), 8'h00);
    send(OP_UNUSED, reg_addr_of(3, REG_VOL_R), 8'hFF);
    send(OP_WRITE, reg_addr_of(0, REG_LEVEL_LO), 8'h00);
    send(OP_WRITE, reg_addr_of(0, REG_LEVEL_HI), 8'h00);
    send(OP_WRITE, reg_addr_of(0, REG_VOL_L), 8'hFF);
    send(OP_WRITE, reg_addr_of(0, REG_VOL_R), 8'hFF);
    send(OP_WRITE, reg_addr_of(1, REG_LEVEL_LO), 8'hFF);
    send(OP_WRITE, reg_addr_of(1, REG_LEVEL_HI), 8'hFF);
    send(OP_WRITE, reg_addr_of(1, REG_VOL_R), 8'h80);
    send(OP_WRITE, reg_addr_of(2, REG_LEVEL_LO), 8'hFF);
    send(OP_WRITE, reg_addr_of(2, REG_LEVEL_HI), 8'h7F);
    send(OP_WRITE, reg_addr_of(2, REG_VOL_L), 8'hFF);
    send(OP_WRITE, reg_addr_of(2, REG_VOL_R), 8'h01);
    send(OP_TICK, reg_addr_of(0, REG_LEVEL_LO), 8'h00);
    send(OP_WRITE, reg_addr_of(0, REG_LEVEL_HI), 8'h80);
    send(OP_WRITE, reg_addr_of(0, REG_RATIO_LO), 8'hFF);
    send(OP_WRITE, reg_addr_of(0, REG_RATIO_HI), 8'hFF);
    send(OP_WRITE, reg_addr_of(0, REG_STEP_LO), 8'hFF);
    send(OP_WRITE, reg_addr_of(0, REG_STEP_HI), 8'hFF);
    send(OP_WRITE, reg_addr_of(3, REG_STEP_HI), 8'h80);
    send(OP_TICK, reg_addr_of(0, REG_LEVEL_LO), 8'h00);
    send(OP_TICK, reg_addr_of(0, REG_LEVEL_LO), 8'h00);
    send(OP_READ, reg_addr_of(0, REG_LEVEL_HI), 8'h00);
    send(OP_READ, reg_addr_of(0, REG_RATIO_HI), 8'h00);
    send(OP_READ, reg_addr_of(0, REG_STEP_HI), 8'h00);
    send(OP_READ, reg_addr_of(0, REG_VOL_R), 8'h00);

    run_random(500);

    // hold off the receiver and keep offering until the block backs up
    wait_for_responses();
    hold_req = 1'b1;
    wait (hold_busy);
    send_idle_on = 1'b0;
    for (int k = 0; k < 12; k++) begin
      send(k[0] ? OP_TICK : OP_READ, rand_addr(), 8'h00);
    end
    send_idle_on = 1'b1;

    run_random(450);

    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    run_random(350);

    wait_for_responses();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lmsg_pkg.sv
sv/lmsg_mul.sv
sv/lmsg_regfile.sv
sv/logistic_map_sound_generator.sv
sim/lmsg_rsp_checker.sv
sim/logistic_map_sound_generator_tb.sv
